/* src/mpm_pkg.sv */
// mpm_pkg: shared types and constants for the multi-period meter
// no dependencies; imported by the result interface, the engine, the top level and the bench
package mpm_pkg;

    // field widths fixed by the register map and the result format
    localparam int PERIOD_W   = 16;
    localparam int TIMEOUT_W  = 32;
    localparam int ELAPSED_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    // register reset values
    localparam logic [PERIOD_W-1:0]  PERIOD_COUNT_RST  = 16'd1000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 32'd10000000;

    // largest reportable count
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // measurement phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_PRE_LOW   = 5'b00010,
        PH_PRE_HIGH  = 5'b00100,
        PH_MEAS_LOW  = 5'b01000,
        PH_MEAS_HIGH = 5'b10000
    } phase_t;

    // configuration handed from the register file to the engine
    typedef struct packed {
        logic [PERIOD_W-1:0]  period_count;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } mpm_cfg_t;

endpackage

/* src/mpm_tick_if.sv */
// mpm_tick_if: request channel carrying one timer tick (pin level, start strobe)
// depends on nothing; valid/ready handshake
interface mpm_tick_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic start_req;

    modport source (output valid, output pin_level, output start_req, input ready);
    modport sink   (input valid, input pin_level, input start_req, output ready);
endinterface

/* src/mpm_result_if.sv */
// mpm_result_if: request channel carrying one measurement result
// depends on mpm_pkg for field widths; valid/ready handshake
interface mpm_result_if;
    import mpm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_ticks;
    logic                 no_signal;

    modport source (output valid, output elapsed_ticks, output no_signal, input ready);
    modport sink   (input valid, input elapsed_ticks, input no_signal, output ready);
endinterface

/* src/mpm_engine.sv */
// mpm_engine: input register, phase/counter state and result register
// depends on mpm_pkg
module mpm_engine #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpm_pkg::mpm_cfg_t              cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           pin_level,
    input  logic                           start_req,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mpm_pkg::ELAPSED_W-1:0]  elapsed_ticks,
    output logic                           no_signal
);
    import mpm_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    logic                    s1_valid_reg;
    logic                    s1_pin_reg;
    logic                    s1_start_reg;
    phase_t                  phase_reg, phase_next;
    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic [PERIOD_W-1:0]     seen_reg, seen_next;
    logic                    res_valid_reg;
    logic [ELAPSED_W-1:0]    res_elapsed_reg;
    logic                    res_nosig_reg;

    logic                    advance;
    logic                    proc;
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]        cnt_ext;
    logic [PERIOD_W-1:0]     seen_inc;
    logic                    arrived;
    logic                    timed_out;
    logic                    emit;
    logic                    emit_nosig;
    logic [ELAPSED_W-1:0]    emit_elapsed;

    // pipeline moves when the result slot is free or being taken
    assign advance  = !res_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign proc     = s1_valid_reg && advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_pin_reg   <= pin_level;
            s1_start_reg <= start_req;
        end
    end

    // saturating count and wait evaluation
    assign cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + COUNTER_BITS'(1);
    assign cnt_ext  = CMP_W'(cnt_inc);
    assign seen_inc = seen_reg + PERIOD_W'(1);
    assign timed_out = cnt_ext > CMP_W'(cfg.timeout_ticks);
    assign arrived  = (phase_reg == PH_PRE_LOW || phase_reg == PH_MEAS_LOW) ?
                      !s1_pin_reg : s1_pin_reg;

    // next state and result for the item in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        seen_next    = seen_reg;
        emit         = 1'b0;
        emit_nosig   = 1'b0;
        emit_elapsed = '0;
        if (s1_start_reg)
        begin
            phase_next = PH_PRE_LOW;
            cnt_next   = '0;
            seen_next  = '0;
        end
        else if (phase_reg != PH_IDLE)
        begin
            cnt_next = cnt_inc;
            if (!arrived)
            begin
                if (timed_out)
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    emit_nosig = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_PRE_LOW:
                    begin
                        phase_next = PH_PRE_HIGH;
                        cnt_next   = '0;
                    end
                    PH_PRE_HIGH:
                    begin
                        phase_next = PH_MEAS_LOW;
                        cnt_next   = '0;
                    end
                    PH_MEAS_LOW:
                    begin
                        phase_next = PH_MEAS_HIGH;
                    end
                    PH_MEAS_HIGH:
                    begin
                        seen_next = seen_inc;
                        if (seen_inc == cfg.period_count)
                        begin
                            phase_next   = PH_IDLE;
                            emit         = 1'b1;
                            emit_elapsed = (cnt_ext > CMP_W'(ELAPSED_MAX)) ?
                                           ELAPSED_MAX : cnt_ext[ELAPSED_W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_MEAS_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            seen_reg  <= '0;
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= proc && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            res_elapsed_reg <= emit_elapsed;
            res_nosig_reg   <= emit_nosig;
        end
    end

    assign out_valid     = res_valid_reg;
    assign elapsed_ticks = res_elapsed_reg;
    assign no_signal     = res_nosig_reg;

    // a no-signal result never carries a count
    a_nosig_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_nosig_reg |-> res_elapsed_reg == '0)
        else $error("no_signal result with nonzero count");

    // a start arms the wait for low with cleared counters
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        proc && s1_start_reg |=> phase_reg == PH_PRE_LOW && cnt_reg == '0 && seen_reg == '0)
        else $error("start did not arm the meter");

    // every result ends the measurement
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        proc && emit |=> phase_reg == PH_IDLE && res_valid_reg)
        else $error("result without return to idle");

    // an idle meter without start produces nothing
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        proc && !s1_start_reg && phase_reg == PH_IDLE |-> !emit && phase_next == PH_IDLE)
        else $error("idle meter produced a result");

endmodule

/* src/multi_period_meter_core.sv */
// multi_period_meter_core: top level, configuration registers and channel hookup
// depends on mpm_pkg, mpm_tick_if, mpm_result_if and mpm_engine
//
// usage:
//   tick_ch carries one request per timer tick: the sampled pin level and a
//   start strobe. start_req arms a measurement (restarting one in progress);
//   the meter waits for the pin to go low, then high, then counts ticks over
//   period_count low-then-high periods and reports the count on result_ch.
//   A wait that runs past timeout_ticks reports no_signal with a zero count.
//   cfg_we/cfg_index/cfg_wdata write period_count (index 0) and
//   timeout_ticks (index 1); write only while no measurement is running.
// timing:
//   one tick accepted every cycle while result_ch is not stalled; a result
//   passes the input register, then the result register, after its tick is accepted.
// reset:
//   the meter goes idle, counters clear, registers return to 1000 periods
//   and a 10000000-tick timeout; no start is pending.
// stall:
//   while a result waits on result_ch.ready, the input register holds one
//   more tick and tick_ch.ready drops once that register is also full.
module multi_period_meter_core #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mpm_tick_if.sink                        tick_ch,
    mpm_result_if.source                    result_ch,
    input  logic                            cfg_we,
    input  logic [mpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import mpm_pkg::*;

    mpm_cfg_t cfg_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_count  <= PERIOD_COUNT_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD_COUNT:  cfg_reg.period_count  <= cfg_wdata[PERIOD_W-1:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // measurement engine
    mpm_engine #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (tick_ch.valid),
        .in_ready      (tick_ch.ready),
        .pin_level     (tick_ch.pin_level),
        .start_req     (tick_ch.start_req),
        .out_valid     (result_ch.valid),
        .out_ready     (result_ch.ready),
        .elapsed_ticks (result_ch.elapsed_ticks),
        .no_signal     (result_ch.no_signal)
    );

endmodule

/* bench/tb_multi_period_meter_core.sv */
`timescale 1ns / 100ps
// tb_multi_period_meter_core: self-checking bench for the multi-period meter
// depends on mpm_pkg, mpm_tick_if, mpm_result_if and multi_period_meter_core
module tb_multi_period_meter_core;
    import mpm_pkg::*;

    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_BUDGET = 170;

    // one measurement result as the meter reports it
    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ticks;
        logic                 no_signal;
    } meter_result_t;

    // tracks the meter from accepted ticks and checks reported results
    class meter_scoreboard;
        logic [PERIOD_W-1:0]  period_count;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        phase_t               phase;
        logic [31:0]          tick_count;
        logic [PERIOD_W-1:0]  periods_seen;
        meter_result_t        pending_results[$];
        int                   failures;

        function new();
            period_count  = PERIOD_COUNT_RST;
            timeout_ticks = TIMEOUT_TICKS_RST;
            phase         = PH_IDLE;
            tick_count    = '0;
            periods_seen  = '0;
            failures      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_PERIOD_COUNT:  period_count  = data[PERIOD_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks = data[TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        // pin level that ends the current wait
        function logic awaited_level();
            return !(phase == PH_PRE_LOW || phase == PH_MEAS_LOW);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_tick(logic pin, logic start);
            meter_result_t res;
            // start only arms, pin is not looked at
            if (start)
            begin
                phase        = PH_PRE_LOW;
                tick_count   = '0;
                periods_seen = '0;
                return;
            end
            if (phase == PH_IDLE)
                return;
            // saturating tick counter
            if (tick_count != '1)
                tick_count++;
            // still waiting: give up once past the timeout
            if (pin != awaited_level())
            begin
                if (tick_count > timeout_ticks)
                begin
                    phase             = PH_IDLE;
                    res.elapsed_ticks = '0;
                    res.no_signal     = 1'b1;
                    pending_results.push_back(res);
                end
                return;
            end
            // awaited level arrived
            case (phase)
                PH_PRE_LOW:
                begin
                    phase      = PH_PRE_HIGH;
                    tick_count = '0;
                end
                PH_PRE_HIGH:
                begin
                    phase      = PH_MEAS_LOW;
                    tick_count = '0;
                end
                PH_MEAS_LOW:
                    phase = PH_MEAS_HIGH;
                default:
                begin
                    periods_seen++;
                    if (periods_seen == period_count)
                    begin
                        phase             = PH_IDLE;
                        res.elapsed_ticks = tick_count;
                        res.no_signal     = 1'b0;
                        pending_results.push_back(res);
                    end
                    else
                        phase = PH_MEAS_LOW;
                end
            endcase
        endfunction

        function void check_result(logic [ELAPSED_W-1:0] elapsed, logic no_signal);
            meter_result_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: elapsed_ticks=%0d no_signal=%0b",
                             elapsed, no_signal);
                return;
            end
            want = pending_results.pop_front();
            if (elapsed !== want.elapsed_ticks || no_signal !== want.no_signal)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: want elapsed=%0d nosig=%0b, got elapsed=%0d nosig=%0b",
                             want.elapsed_ticks, want.no_signal, elapsed, no_signal);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    mpm_tick_if   tick_ch();
    mpm_result_if result_ch();

    meter_scoreboard sb = new();

    int tx_idle_pct;
    int rx_idle_pct;
    int sent_items;

    multi_period_meter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_ch   (tick_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always #5 clk = ~clk;

    // result receiver with random stalls
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.elapsed_ticks, result_ch.no_signal);
    end

    // one tick request, with random idle cycles ahead of it
    task automatic send_tick(logic pin, logic start);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            tick_ch.valid <= 1'b0;
        end
        @(negedge clk);
        tick_ch.valid     <= 1'b1;
        tick_ch.pin_level <= pin;
        tick_ch.start_req <= start;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        sent_items++;
        sb.note_tick(pin, start);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // bring the meter idle: finish the measurement or let it time out,
    // whichever takes fewer ticks
    task automatic drive_to_idle();
        longint unsigned target;
        longint unsigned finish_cost;
        longint unsigned timeout_cost;
        bit              hold;
        target      = (sb.period_count == 0) ? 65536 : sb.period_count;
        finish_cost = 2 * (target - sb.periods_seen) + 4;
        if (sb.timeout_ticks == '1)
            timeout_cost = 64'hFFFF_FFFF_FFFF;
        else if (sb.tick_count > sb.timeout_ticks)
            timeout_cost = 1;
        else
            timeout_cost = sb.timeout_ticks - sb.tick_count + 1;
        hold = timeout_cost < finish_cost;
        while (sb.busy())
            send_tick(hold ? !sb.awaited_level() : sb.awaited_level(), 1'b0);
    endtask

    // stop requests and wait for every expected result plus pipeline latency
    task automatic settle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly well-formed square waves after a start, some noise
    task automatic run_random(int budget);
        int goal;
        int cycles;
        int half_max;
        goal = sent_items + budget;
        while (sent_items < goal)
        begin
            if ($urandom_range(99) < 85)
            begin
                send_tick(1'($urandom_range(1)), 1'b1);
                repeat ($urandom_range(3)) send_tick(1'b1, 1'b0);
                if ($urandom_range(99) < 70)
                    cycles = sb.period_count + 1;
                else
                    cycles = $urandom_range(sb.period_count + 2);
                half_max = $urandom_range(1, 16);
                repeat (cycles)
                begin
                    repeat ($urandom_range(1, half_max)) send_tick(1'b0, 1'b0);
                    repeat ($urandom_range(1, half_max)) send_tick(1'b1, 1'b0);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_tick(1'($urandom_range(1)), $urandom_range(99) < 20);
            end
        end
    endtask

    // full measurement of a one-tick-per-level square wave
    task automatic run_square(int periods);
        send_tick(1'b1, 1'b1);
        repeat (periods + 1)
        begin
            send_tick(1'b0, 1'b0);
            send_tick(1'b1, 1'b0);
        end
    endtask

    // one register setting: idle the meter, write both registers, run
    task automatic run_setting(logic [PERIOD_W-1:0] period, logic [TIMEOUT_W-1:0] timeout,
                               bit full_square);
        drive_to_idle();
        settle();
        write_reg(REG_PERIOD_COUNT, CFG_DATA_W'(period));
        write_reg(REG_TIMEOUT_TICKS, timeout);
        if (full_square)
            run_square((period == 0) ? 65536 : period);
        else
            run_random(RANDOM_BUDGET);
    endtask

    // main sequence
    initial
    begin
        rst_n             = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.pin_level = 1'b0;
        tick_ch.start_req = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_PERIOD_COUNT;
        cfg_wdata         = '0;
        sent_items        = 0;
        tx_idle_pct       = 19;
        rx_idle_pct       = 58;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: ticks while idle, start with either pin level, restarts,
        // waits that do not arrive, a few periods at the reset setting
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);

        // zero timeout and the smallest settings
        run_setting(16'd1, 32'd0, 1'b0);
        run_setting(16'd1, 32'd1, 1'b0);

        tx_idle_pct = 58;
        rx_idle_pct = 19;
        run_setting(16'd2, 32'd12, 1'b0);
        run_setting(16'd3, 32'd40, 1'b0);

        // largest timeout, back-to-back square wave, and the wrapped zero
        // period count that runs into the measurement timeout
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_setting(16'd40, 32'hFFFF_FFFF, 1'b1);
        run_setting(16'd5, 32'hFFFF_FFFF, 1'b0);
        run_setting(16'd0, 32'd60, 1'b0);
        run_setting(16'd4, 32'd25, 1'b0);

        settle();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
src/mpm_pkg.sv
src/mpm_tick_if.sv
src/mpm_result_if.sv
src/mpm_engine.sv
src/multi_period_meter_core.sv
bench/tb_multi_period_meter_core.sv
